FILE: hw/rtl/hapsel_pkg.sv
// ----------------------------------------------------------------------------
// hapsel_pkg
// shared types and constants for the hold-to-advance program selector
// ----------------------------------------------------------------------------
`default_nettype none

package hapsel_pkg;

    // upper limit on the number of programs the selector cycles through
    localparam int unsigned MAX_PROGRAMS = 256;

    localparam int unsigned COUNT_W   = 9;
    localparam int unsigned PROG_W    = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // effective program count limit, bounded by the range of the program number
    localparam int unsigned COUNT_LIMIT_INT =
        (MAX_PROGRAMS < (1 << PROG_W)) ? MAX_PROGRAMS : (1 << PROG_W);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_INT);

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROG_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REARM_LIMIT = 2'd2;

    // configuration reset values
    localparam logic [COUNT_W-1:0] PROG_TOTAL_RST  = 9'd1;
    localparam logic [TIME_W-1:0]  HOLD_LIMIT_RST  = 32'd500;
    localparam logic [TIME_W-1:0]  REARM_LIMIT_RST = 32'd50;

    typedef struct packed {
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] release_time;
        logic              latch_flag;
        logic [PROG_W-1:0] program_now;
    } sel_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] prog_total;
        logic [TIME_W-1:0]  hold_limit;
        logic [TIME_W-1:0]  rearm_limit;
    } sel_cfg_t;

    typedef struct packed {
        logic              opcode;
        logic              pressed;
        logic [ELAPSED_W-1:0] delta_ms;
        logic [PROG_W-1:0] program_req;
    } sel_word_t;

    typedef struct packed {
        logic              status;
        logic              prog_stepped;
        logic [PROG_W-1:0] active_prog;
    } sel_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hapsel_step.sv
// ----------------------------------------------------------------------------
// hapsel_step
// next-state and result logic for one input word
// ----------------------------------------------------------------------------
`default_nettype none

module hapsel_step (
    input  wire  hapsel_pkg::sel_cfg_t    cfg,
    input  wire  hapsel_pkg::sel_state_t  state_cur,
    input  wire  hapsel_pkg::sel_word_t   word,
    output hapsel_pkg::sel_state_t        state_nxt,
    output hapsel_pkg::sel_result_t       result
);
    import hapsel_pkg::*;

    logic [COUNT_W-1:0] count;
    logic [TIME_W:0]    press_sum;
    logic [TIME_W:0]    release_sum;
    logic [TIME_W-1:0]  press_sat;
    logic [TIME_W-1:0]  release_sat;
    logic [COUNT_W-1:0] prog_inc;

    always_comb
    begin
        count = (cfg.prog_total > COUNT_LIMIT) ? COUNT_LIMIT : cfg.prog_total;

        // saturating accumulate of the elapsed time
        press_sum   = {1'b0, state_cur.press_time} + {{(TIME_W+1-ELAPSED_W){1'b0}}, word.delta_ms};
        release_sum = {1'b0, state_cur.release_time} + {{(TIME_W+1-ELAPSED_W){1'b0}}, word.delta_ms};
        press_sat   = press_sum[TIME_W] ? {TIME_W{1'b1}} : press_sum[TIME_W-1:0];
        release_sat = release_sum[TIME_W] ? {TIME_W{1'b1}} : release_sum[TIME_W-1:0];

        prog_inc = {1'b0, state_cur.program_now} + COUNT_W'(1);

        state_nxt = state_cur;
        result.status       = STATUS_OK;
        result.prog_stepped = 1'b0;

        if (count == '0)
        begin
            result.status = STATUS_INVALID;
        end
        else if (word.opcode == OP_SELECT)
        begin
            if ({1'b0, word.program_req} >= count)
            begin
                result.status = STATUS_INVALID;
            end
            else
            begin
                state_nxt.program_now  = word.program_req;
                state_nxt.press_time   = '0;
                state_nxt.release_time = '0;
                state_nxt.latch_flag   = 1'b0;
            end
        end
        else if (!word.pressed)
        begin
            state_nxt.press_time   = '0;
            state_nxt.release_time = '0;
            // released: count toward rearm only while latched
            if (state_cur.latch_flag && (release_sat < cfg.rearm_limit))
            begin
                state_nxt.release_time = release_sat;
            end
            else if (state_cur.latch_flag)
            begin
                state_nxt.latch_flag = 1'b0;
            end
        end
        else
        begin
            state_nxt.release_time = '0;
            if (!state_cur.latch_flag)
            begin
                if (press_sat >= cfg.hold_limit)
                begin
                    if (count > COUNT_W'(1))
                    begin
                        // compare-and-wrap, also covers a count lowered below the program
                        state_nxt.program_now = (prog_inc >= count) ? '0 : prog_inc[PROG_W-1:0];
                        result.prog_stepped = 1'b1;
                    end
                    state_nxt.press_time = '0;
                    state_nxt.latch_flag = 1'b1;
                end
                else
                begin
                    state_nxt.press_time = press_sat;
                end
            end
        end

        result.active_prog = state_nxt.program_now;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hold_to_advance_program_selector_top.sv
// ----------------------------------------------------------------------------
// hold_to_advance_program_selector_top
// long-press switch handler that steps through a cycle of programs
// ----------------------------------------------------------------------------
// Each input word (a switch sample or a direct program select) produces one
// result word. A word is captured into an input register, processed against
// the timer/latch/program state, and the result lands in an output register.
// With no output stall a new word is taken every clock, so throughput is one
// word per clock; out_valid is the valid flag of the output register. A result
// held by out_stall keeps the input register full, which then stalls the
// input. The state update of one word is visible to the very next word.
// Configuration writes take effect at once and are meant for idle periods only.
`default_nettype none

module hold_to_advance_program_selector_top (
    input  wire                                   clk,
    input  wire                                   rst_n,

    input  wire                                   cfg_we,
    input  wire  [hapsel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [hapsel_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire                                   opcode,
    input  wire                                   pressed,
    input  wire  [hapsel_pkg::ELAPSED_W-1:0]      delta_ms,
    input  wire  [hapsel_pkg::PROG_W-1:0]         program_req,

    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic                                  status,
    output logic                                  prog_stepped,
    output logic [hapsel_pkg::PROG_W-1:0]         active_prog
);
    import hapsel_pkg::*;

    sel_cfg_t    cfg_reg;
    sel_state_t  state_reg;
    sel_state_t  state_next;
    sel_word_t   word_reg;
    logic        word_vld_reg;
    sel_result_t res_reg;
    sel_result_t res_next;
    logic        res_vld_reg;

    logic        in_take;
    logic        advance;

    always_comb
    begin
        advance  = word_vld_reg && (!res_vld_reg || !out_stall);
        in_stall = word_vld_reg && !advance;
        in_take  = in_valid && !in_stall;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prog_total  <= PROG_TOTAL_RST;
            cfg_reg.hold_limit  <= HOLD_LIMIT_RST;
            cfg_reg.rearm_limit <= REARM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROG_TOTAL:  cfg_reg.prog_total  <= cfg_data[COUNT_W-1:0];
                REG_HOLD_LIMIT:  cfg_reg.hold_limit  <= cfg_data[TIME_W-1:0];
                REG_REARM_LIMIT: cfg_reg.rearm_limit <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            word_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            word_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg.opcode      <= opcode;
            word_reg.pressed     <= pressed;
            word_reg.delta_ms    <= delta_ms;
            word_reg.program_req <= program_req;
        end
    end

    hapsel_step u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .word      (word_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    // selector state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = res_vld_reg;
    assign status       = res_reg.status;
    assign prog_stepped = res_reg.prog_stepped;
    assign active_prog  = res_reg.active_prog;

endmodule

`default_nettype wire

FILE: test/tb_hold_to_advance_program_selector_top.sv
// ----------------------------------------------------------------------------
// tb_hold_to_advance_program_selector_top
// self-checking bench for the hold-to-advance program selector
// ----------------------------------------------------------------------------
// A short table of hand-picked words and configurations runs first, with the
// result typed in where it is obvious. Random phases follow, each with its own
// configuration and mostly well-formed press/release sequences. Every accepted
// word is run through an in-bench model of the selector, and each result word
// is compared field by field against the oldest outstanding prediction.
`default_nettype none

module tb_hold_to_advance_program_selector_top;

    import hapsel_pkg::*;

    localparam int RUN_LIMIT = 4_000_000;

    typedef enum logic [1:0] {ROW_TYPED, ROW_PRED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        sel_word_t   word;
        sel_result_t res;
        sel_cfg_t    cfg;
    } dir_row_t;

    localparam sel_word_t   NO_WORD = '0;
    localparam sel_result_t NO_RES  = '0;
    localparam sel_cfg_t    NO_CFG  = '0;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    opcode = 1'b0;
    logic                    pressed = 1'b0;
    logic [ELAPSED_W-1:0]    delta_ms = '0;
    logic [PROG_W-1:0]       program_req = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    status;
    logic                    prog_stepped;
    logic [PROG_W-1:0]       active_prog;

    // selector model: configuration and state as the block should hold them
    sel_cfg_t    cfg_now;
    sel_state_t  st_now;
    sel_result_t program_reports[$];

    int mismatches = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    dir_row_t dir_rows [30] = '{
        // reset configuration: one program, hold 500, rearm 50
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd255},
            '{STATUS_INVALID, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd1},
            '{STATUS_INVALID, 1'b0, 8'd0}, NO_CFG},
        // single program: hold latches but nothing advances
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'hFFFF,  8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'hFFFF,  8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd10,    8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd40,    8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        // zero thresholds are met at once
        '{ROW_CFG, NO_WORD, NO_RES, '{9'd256, 32'd0, 32'd0}},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd0,     8'd0},   '{STATUS_OK, 1'b1, 8'd1}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd1}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd1}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd255}, '{STATUS_OK, 1'b0, 8'd255}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd0,     8'd0},   '{STATUS_OK, 1'b1, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b1, 16'hFFFF,  8'd254}, '{STATUS_OK, 1'b0, 8'd254}, NO_CFG},
        // count lowered below the current program, next advance wraps
        '{ROW_CFG, NO_WORD, NO_RES, '{9'd3, 32'd1000, 32'd100}},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd999,   8'd0},   '{STATUS_OK, 1'b0, 8'd254}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd1,     8'd0},   '{STATUS_OK, 1'b1, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd3},
            '{STATUS_INVALID, 1'b0, 8'd0}, NO_CFG},
        // zero programs: everything is rejected
        '{ROW_CFG, NO_WORD, NO_RES, '{9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'hFFFF,  8'd0},
            '{STATUS_INVALID, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd0},
            '{STATUS_INVALID, 1'b0, 8'd0}, NO_CFG},
        // oversized count behaves as 256
        '{ROW_CFG, NO_WORD, NO_RES, '{9'd511, 32'd1, 32'd1}},
        '{ROW_TYPED, '{OP_SELECT, 1'b0, 16'd0,     8'd255}, '{STATUS_OK, 1'b0, 8'd255}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd255}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b1, 16'd1,     8'd0},   '{STATUS_OK, 1'b1, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd0,     8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_TYPED, '{OP_SAMPLE, 1'b0, 16'd1,     8'd0},   '{STATUS_OK, 1'b0, 8'd0}, NO_CFG},
        '{ROW_PRED,  '{OP_SAMPLE, 1'b1, 16'hFFFF,  8'hAA},  NO_RES, NO_CFG},
        '{ROW_PRED,  '{OP_SAMPLE, 1'b0, 16'h5555,  8'h55},  NO_RES, NO_CFG}
    };

    hold_to_advance_program_selector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .pressed      (pressed),
        .delta_ms     (delta_ms),
        .program_req  (program_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .prog_stepped (prog_stepped),
        .active_prog  (active_prog)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // one switch sample or select applied to the model state
    task automatic selector_step(input sel_word_t w, output sel_result_t r);
        int unsigned cnt;
        int unsigned nxt;
        logic [32:0] sum;
        begin
            cnt = 32'(cfg_now.prog_total);
            if (cnt > MAX_PROGRAMS)
                cnt = MAX_PROGRAMS;
            if (cnt > 256)
                cnt = 256;
            r = '0;
            r.status = STATUS_OK;
            if (cnt == 0)
            begin
                r.status = STATUS_INVALID;
            end
            else if (w.opcode == OP_SELECT)
            begin
                if (32'(w.program_req) >= cnt)
                begin
                    r.status = STATUS_INVALID;
                end
                else
                begin
                    st_now.program_now = w.program_req;
                    st_now.press_time = '0;
                    st_now.release_time = '0;
                    st_now.latch_flag = 1'b0;
                end
            end
            else if (!w.pressed)
            begin
                st_now.press_time = '0;
                if (st_now.latch_flag)
                begin
                    sum = {1'b0, st_now.release_time} + 33'(w.delta_ms);
                    st_now.release_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (st_now.release_time >= cfg_now.rearm_limit)
                    begin
                        st_now.latch_flag = 1'b0;
                        st_now.release_time = '0;
                    end
                end
                else
                begin
                    st_now.release_time = '0;
                end
            end
            else
            begin
                st_now.release_time = '0;
                if (!st_now.latch_flag)
                begin
                    sum = {1'b0, st_now.press_time} + 33'(w.delta_ms);
                    st_now.press_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (st_now.press_time >= cfg_now.hold_limit)
                    begin
                        if (cnt > 1)
                        begin
                            nxt = 32'(st_now.program_now) + 32'd1;
                            if (nxt >= cnt)
                                nxt = 0;
                            st_now.program_now = nxt[7:0];
                            r.prog_stepped = 1'b1;
                        end
                        st_now.press_time = '0;
                        st_now.latch_flag = 1'b1;
                    end
                end
            end
            r.active_prog = st_now.program_now;
        end
    endtask

    task automatic load_config(input logic [31:0] count_word, input logic [31:0] hold,
                               input logic [31:0] rearm);
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_PROG_TOTAL;
            cfg_data <= count_word;
            @(posedge clk);
            cfg_index <= REG_HOLD_LIMIT;
            cfg_data <= hold;
            @(posedge clk);
            cfg_index <= REG_REARM_LIMIT;
            cfg_data <= rearm;
            @(posedge clk);
            cfg_we <= 1'b0;
            cfg_now.prog_total = count_word[COUNT_W-1:0];
            cfg_now.hold_limit = hold;
            cfg_now.rearm_limit = rearm;
        end
    endtask

    // present a word, hold it until taken, then record what should come back
    task automatic send_word(input sel_word_t w, input bit typed, input sel_result_t typed_res);
        sel_result_t r;
        begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            in_valid <= 1'b1;
            opcode <= w.opcode;
            pressed <= w.pressed;
            delta_ms <= w.delta_ms;
            program_req <= w.program_req;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            selector_step(w, r);
            program_reports.push_back(typed ? typed_res : r);
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (program_reports.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    function automatic int idle_share();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom;
            default: return 32'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        sel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (program_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, expected none actual program %0d",
                         $time, active_prog);
            end
            else
            begin
                want = program_reports.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("prog_stepped", 32'(want.prog_stepped), 32'(prog_stepped));
                check_field("active_prog", 32'(want.active_prog), 32'(active_prog));
            end
        end
    end

    // output back-pressure in randomly timed bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(1, 10);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("** hold_to_advance_program_selector_top: FAILED **");
        $finish;
    end

    initial
    begin
        sel_word_t   w;
        logic [31:0] count_word;
        logic [31:0] thr;
        int unsigned cnt_eff;
        int unsigned scale;
        int unsigned roll;
        bit          held_level;

        cfg_now.prog_total = PROG_TOTAL_RST;
        cfg_now.hold_limit = HOLD_LIMIT_RST;
        cfg_now.rearm_limit = REARM_LIMIT_RST;
        st_now = '0;
        held_level = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 20;
        stall_pct = 20;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                load_config(32'(dir_rows[i].cfg.prog_total),
                            dir_rows[i].cfg.hold_limit,
                            dir_rows[i].cfg.rearm_limit);
            end
            else
            begin
                send_word(dir_rows[i].word, dir_rows[i].kind == ROW_TYPED, dir_rows[i].res);
            end
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            if (phase == 9)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = idle_share();
                stall_pct = idle_share();
            end
            case ($urandom_range(0, 11))
                0: count_word = 32'd0;
                1: count_word = 32'd1;
                2: count_word = 32'd2;
                3: count_word = 32'd256;
                4: count_word = 32'($urandom_range(257, 511));
                5: count_word = 32'($urandom_range(1, 256));
                default: count_word = 32'($urandom_range(3, 12));
            endcase
            // upper bits of the count write are not part of the register
            if ($urandom_range(0, 3) == 0)
                count_word[31:COUNT_W] = 23'($urandom);
            load_config(count_word, pick_duration(), pick_duration());
            cnt_eff = (cfg_now.prog_total > 9'd256) ? 32'd256 : 32'(cfg_now.prog_total);

            repeat (125)
            begin
                w.opcode = OP_SAMPLE;
                w.pressed = 1'($urandom_range(0, 1));
                w.delta_ms = 16'($urandom);
                w.program_req = 8'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    w.opcode = 1'($urandom_range(0, 1));
                end
                else if (roll < 20)
                begin
                    w.opcode = OP_SELECT;
                    if ($urandom_range(0, 3) != 0)
                        w.program_req = 8'($urandom_range(0, (cnt_eff >= 255) ? 255 : cnt_eff + 1));
                end
                else
                begin
                    if ($urandom_range(0, 5) == 0)
                        held_level = !held_level;
                    w.pressed = held_level;
                    thr = held_level ? cfg_now.hold_limit : cfg_now.rearm_limit;
                    // step size scaled so a few samples reach the threshold
                    scale = (thr / 3 >= 65535) ? 65535 : thr / 3 + 1;
                    case ($urandom_range(0, 9))
                        0: w.delta_ms = 16'd0;
                        1: w.delta_ms = 16'hFFFF;
                        default: w.delta_ms = 16'($urandom_range(0, scale));
                    endcase
                end
                send_word(w, 1'b0, NO_RES);
            end
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("** hold_to_advance_program_selector_top: PASSED **");
        else
            $display("** hold_to_advance_program_selector_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
